### rtl/core/ipc_pkg.sv
`timescale 1ns / 1ps

package ipc_pkg;

    // Palette geometry
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_IDX_W   = 8;
    localparam int RGB_W       = 24;

    // Result field widths
    localparam int OUT_X_W     = 9;
    localparam int OUT_Y_W     = 8;
    localparam int CHAN_W      = 8;

    // Output queue
    localparam int OQ_DEPTH    = 8;
    localparam int OQ_PTR_W    = 3;
    localparam int OQ_CNT_W    = 4;

    // Action codes
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_PIXEL   = 1'b1;

    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_out_item;

    // RGB565 -> RGB888, top bits repeated into the freed low bits
    function automatic logic [RGB_W-1:0] widen565(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {c[15:11], c[15:13]};
        g = {c[10:5], c[10:9]};
        b = {c[4:0], c[4:2]};
        return {r, g, b};
    endfunction

endpackage

### rtl/core/ipc_in_if.sv
`timescale 1ns / 1ps

interface ipc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  palette_slot;
    logic [15:0] palette_color;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [7:0]  color_index;
    logic        use_transparency;
    logic [7:0]  transparent_index;

    modport source (
        output valid, action, palette_slot, palette_color, pixel_x, pixel_y,
               color_index, use_transparency, transparent_index,
        input  ready
    );
    modport sink (
        input  valid, action, palette_slot, palette_color, pixel_x, pixel_y,
               color_index, use_transparency, transparent_index,
        output ready
    );
endinterface

### rtl/core/ipc_out_if.sv
`timescale 1ns / 1ps

interface ipc_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] out_x;
    logic [7:0] out_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid, out_x, out_y, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, red, green, blue,
        output ready
    );
endinterface

### rtl/core/ipc_ram.sv
`timescale 1ns / 1ps

module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ipc_outq.sv
`timescale 1ns / 1ps

module ipc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ipc_pkg::t_out_item i_data,
    ipc_out_if.source         o_out
);

    ipc_pkg::t_out_item              r_mem [ipc_pkg::OQ_DEPTH];
    logic [ipc_pkg::OQ_PTR_W-1:0]    r_wr_ptr;
    logic [ipc_pkg::OQ_PTR_W-1:0]    r_rd_ptr;
    logic [ipc_pkg::OQ_CNT_W-1:0]    r_count;
    logic [ipc_pkg::OQ_CNT_W-1:0]    n_count;
    logic                            w_pop;
    ipc_pkg::t_out_item              w_head;

    assign w_pop   = o_out.valid && o_out.ready;
    assign w_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_out.valid = (r_count != '0);
    assign o_out.out_x = w_head.out_x;
    assign o_out.out_y = w_head.out_y;
    assign o_out.red   = w_head.red;
    assign o_out.green = w_head.green;
    assign o_out.blue  = w_head.blue;

`ifndef SYNTH
    // upstream credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < ipc_pkg::OQ_CNT_W'(ipc_pkg::OQ_DEPTH)) || w_pop)
        else $error("output queue overflow");
`endif

endmodule

### rtl/core/indexed_pixel_compositor.sv
`timescale 1ns / 1ps

// Indexed pixel compositor.
// i_in (sink): one transfer per item. action = palette write stores an RGB565
//   color, widened to RGB888, in one of 256 palette slots. action = pixel writes
//   color_index into the frame buffer at (pixel_x, pixel_y) unless it matches an
//   enabled transparent index, then looks the stored index up in the palette.
// o_out (source): one transfer per on-screen pixel with x, y, R, G, B.
//   Palette writes and off-screen pixels give no transfer.
// Throughput: one item per cycle, sustained, as long as o_out is drained.
// An accepted pixel reaches o_out through the frame read, the read-modify-write
//   with palette read, and the push to the output queue.
// Frame buffer and palette live in single-write, single-read RAMs with a
//   registered read; back-to-back pixels to the same location are forwarded
//   from the last write.
// Reset: a clear pass writes zero to every frame location (and the palette in
//   parallel); i_in.ready stays low until it is done.
// Stall: an 8-entry output queue with a credit count takes results while the
//   receiver holds off; i_in.ready drops once 8 pixels are outstanding.

module indexed_pixel_compositor #(
    parameter int DISP_WIDTH  = 320,
    parameter int DISP_HEIGHT = 240
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ipc_in_if.sink    i_in,
    ipc_out_if.source o_out
);

    localparam int FRAME_SIZE = DISP_WIDTH * DISP_HEIGHT;
    localparam int FA_W       = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
    localparam int CLEAR_LEN  = (FRAME_SIZE > ipc_pkg::PAL_DEPTH) ? FRAME_SIZE
                                                                  : ipc_pkg::PAL_DEPTH;
    localparam int CLR_W      = $clog2(CLEAR_LEN + 1);
    localparam int POS_W      = 21;

    // ---------------- clear pass ----------------
    logic             r_clearing;
    logic [CLR_W-1:0] r_clr_cnt;
    logic             w_clr_pal;
    logic             w_clr_frame;

    assign w_clr_pal   = r_clearing && (r_clr_cnt < CLR_W'(ipc_pkg::PAL_DEPTH));
    assign w_clr_frame = r_clearing && (r_clr_cnt < CLR_W'(FRAME_SIZE));

    // ---------------- accept / decode ----------------
    logic [ipc_pkg::OQ_CNT_W-1:0] r_credit;
    logic [ipc_pkg::OQ_CNT_W-1:0] n_credit;
    logic                         w_accept;
    logic                         w_on_screen;
    logic                         w_take_pix;
    logic                         w_take_pal;
    logic [POS_W-1:0]             w_pos;
    logic                         w_pop;

    assign i_in.ready = !r_clearing && (r_credit < ipc_pkg::OQ_CNT_W'(ipc_pkg::OQ_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pop      = o_out.valid && o_out.ready;

    assign w_on_screen = ({1'b0, i_in.pixel_x} < 11'(DISP_WIDTH))
                      && ({1'b0, i_in.pixel_y} < 11'(DISP_HEIGHT));
    assign w_take_pix  = w_accept && (i_in.action == ipc_pkg::ACT_PIXEL) && w_on_screen;
    assign w_take_pal  = w_accept && (i_in.action == ipc_pkg::ACT_PALETTE);

    // row-major location; one narrow multiply, registered into stage 1
    assign w_pos = POS_W'(i_in.pixel_y) * POS_W'(DISP_WIDTH) + POS_W'(i_in.pixel_x);

    // credit covers every pixel in flight or queued
    always_comb begin
        n_credit = r_credit;
        if (w_take_pix && !w_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_take_pix && w_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    // ---------------- pipeline registers ----------------
    // stage 1: frame read issued, palette write done
    logic                              r_s1_pix;
    logic                              r_s1_pal;
    logic [FA_W-1:0]                   r_s1_addr;
    logic [ipc_pkg::PAL_IDX_W-1:0]     r_s1_slot;
    logic [ipc_pkg::RGB_W-1:0]         r_s1_rgb;
    logic [ipc_pkg::PAL_IDX_W-1:0]     r_s1_ci;
    logic                              r_s1_transp;
    logic [ipc_pkg::OUT_X_W-1:0]       r_s1_x;
    logic [ipc_pkg::OUT_Y_W-1:0]       r_s1_y;
    // stage 2: frame data back, resolve index, write back, palette read
    logic                              r_s2_pix;
    logic [FA_W-1:0]                   r_s2_addr;
    logic [ipc_pkg::PAL_IDX_W-1:0]     r_s2_ci;
    logic                              r_s2_transp;
    logic [ipc_pkg::OUT_X_W-1:0]       r_s2_x;
    logic [ipc_pkg::OUT_Y_W-1:0]       r_s2_y;
    // stage 3: palette data back, push to queue
    logic                              r_s3_pix;
    logic [ipc_pkg::OUT_X_W-1:0]       r_s3_x;
    logic [ipc_pkg::OUT_Y_W-1:0]       r_s3_y;
    // last frame write, for a read that raced it
    logic                              r_fw_valid;
    logic [FA_W-1:0]                   r_fw_addr;
    logic [ipc_pkg::PAL_IDX_W-1:0]     r_fw_idx;

    // ---------------- frame buffer ----------------
    logic                              w_fb_we;
    logic [FA_W-1:0]                   w_fb_waddr;
    logic [ipc_pkg::PAL_IDX_W-1:0]     w_fb_wdata;
    logic [ipc_pkg::PAL_IDX_W-1:0]     w_fb_rdata;
    logic [ipc_pkg::PAL_IDX_W-1:0]     w_old_idx;
    logic [ipc_pkg::PAL_IDX_W-1:0]     w_s2_idx;
    logic                              w_fwd_hit;

    assign w_fwd_hit = r_fw_valid && (r_fw_addr == r_s2_addr);
    assign w_old_idx = w_fwd_hit ? r_fw_idx : w_fb_rdata;
    assign w_s2_idx  = r_s2_transp ? w_old_idx : r_s2_ci;

    // a transparent pixel writes back the index it keeps
    assign w_fb_we    = w_clr_frame || r_s2_pix;
    assign w_fb_waddr = r_clearing ? r_clr_cnt[FA_W-1:0] : r_s2_addr;
    assign w_fb_wdata = r_clearing ? '0 : w_s2_idx;

    ipc_ram #(
        .WIDTH (ipc_pkg::PAL_IDX_W),
        .DEPTH (FRAME_SIZE)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_fb_we),
        .i_waddr (w_fb_waddr),
        .i_wdata (w_fb_wdata),
        .i_raddr (r_s1_addr),
        .o_rdata (w_fb_rdata)
    );

    // ---------------- palette ----------------
    // written in stage 1 so an earlier pixel reading in stage 2 the same cycle
    // still gets the old color
    logic                              w_pal_we;
    logic [ipc_pkg::PAL_IDX_W-1:0]     w_pal_waddr;
    logic [ipc_pkg::RGB_W-1:0]         w_pal_wdata;
    logic [ipc_pkg::RGB_W-1:0]         w_pal_rdata;

    assign w_pal_we    = w_clr_pal || r_s1_pal;
    assign w_pal_waddr = r_clearing ? r_clr_cnt[ipc_pkg::PAL_IDX_W-1:0] : r_s1_slot;
    assign w_pal_wdata = r_clearing ? '0 : r_s1_rgb;

    ipc_ram #(
        .WIDTH (ipc_pkg::RGB_W),
        .DEPTH (ipc_pkg::PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (w_pal_waddr),
        .i_wdata (w_pal_wdata),
        .i_raddr (w_s2_idx),
        .o_rdata (w_pal_rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_credit   <= '0;
            r_s1_pix   <= 1'b0;
            r_s1_pal   <= 1'b0;
            r_s2_pix   <= 1'b0;
            r_s3_pix   <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(CLEAR_LEN - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_credit   <= n_credit;
            r_s1_pix   <= w_take_pix;
            r_s1_pal   <= w_take_pal;
            r_s2_pix   <= r_s1_pix;
            r_s3_pix   <= r_s2_pix;
            r_fw_valid <= r_s2_pix;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_s1_addr   <= w_pos[FA_W-1:0];
        r_s1_slot   <= i_in.palette_slot;
        r_s1_rgb    <= ipc_pkg::widen565(i_in.palette_color);
        r_s1_ci     <= i_in.color_index;
        r_s1_transp <= i_in.use_transparency
                    && (i_in.color_index == i_in.transparent_index);
        r_s1_x      <= i_in.pixel_x[ipc_pkg::OUT_X_W-1:0];
        r_s1_y      <= i_in.pixel_y[ipc_pkg::OUT_Y_W-1:0];

        r_s2_addr   <= r_s1_addr;
        r_s2_ci     <= r_s1_ci;
        r_s2_transp <= r_s1_transp;
        r_s2_x      <= r_s1_x;
        r_s2_y      <= r_s1_y;

        r_s3_x      <= r_s2_x;
        r_s3_y      <= r_s2_y;

        r_fw_addr   <= r_s2_addr;
        r_fw_idx    <= w_s2_idx;
    end

    // ---------------- output queue ----------------
    ipc_pkg::t_out_item w_push_item;

    assign w_push_item.out_x = r_s3_x;
    assign w_push_item.out_y = r_s3_y;
    assign w_push_item.red   = w_pal_rdata[23:16];
    assign w_push_item.green = w_pal_rdata[15:8];
    assign w_push_item.blue  = w_pal_rdata[7:0];

    ipc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_pix),
        .i_data  (w_push_item),
        .o_out   (o_out)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= ipc_pkg::OQ_CNT_W'(ipc_pkg::OQ_DEPTH))
        else $error("credit count above queue depth");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_in.ready && !r_s1_pix && !r_s1_pal)
        else $error("pipeline active during clear pass");

    a_credit_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_pix || o_out.valid) |-> (r_credit != '0))
        else $error("result without credit");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DISP_W       = 320;
    localparam int DISP_H       = 240;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in the stall test
    localparam int DRAIN_CYCLES = 24;    // idle after the last expected pixel to catch stray transfers
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        logic        action;
        logic [7:0]  palette_slot;
        logic [15:0] palette_color;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [7:0]  color_index;
        logic        use_transparency;
        logic [7:0]  transparent_index;
    } t_cmd;

    logic i_clk;
    logic i_rst_n;

    ipc_in_if  in_if ();
    ipc_out_if out_if ();

    indexed_pixel_compositor #(
        .DISP_WIDTH  (DISP_W),
        .DISP_HEIGHT (DISP_H)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow state: palette in RGB888, frame buffer of indices.
    bit [23:0] palette_rgb [ipc_pkg::PAL_DEPTH];
    bit [7:0]  frame_idx [DISP_W*DISP_H];

    ipc_pkg::t_out_item pending_pixels [$];
    int unsigned mismatch_count;
    int unsigned src_burst;
    bit          hold_req;   // toggled to ask the receiver for a long hold-off

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Update the shadow state for one accepted command and queue the pixel it
    // should produce, if any.
    task automatic predict_composite(input t_cmd cmd);
        int unsigned        pos;
        bit [23:0]          rgb;
        ipc_pkg::t_out_item res;
        if (cmd.action == ipc_pkg::ACT_PALETTE) begin
            palette_rgb[cmd.palette_slot] = {
                cmd.palette_color[15:11], cmd.palette_color[15:13],
                cmd.palette_color[10:5],  cmd.palette_color[10:9],
                cmd.palette_color[4:0],   cmd.palette_color[4:2]};
            return;
        end
        if (cmd.pixel_y >= DISP_H || cmd.pixel_x >= DISP_W) return;
        pos = cmd.pixel_y * DISP_W + cmd.pixel_x;
        if (!(cmd.use_transparency && cmd.color_index == cmd.transparent_index)) begin
            frame_idx[pos] = cmd.color_index;
        end
        rgb = palette_rgb[frame_idx[pos]];
        res.out_x = cmd.pixel_x[8:0];
        res.out_y = cmd.pixel_y[7:0];
        res.red   = rgb[23:16];
        res.green = rgb[15:8];
        res.blue  = rgb[7:0];
        pending_pixels.push_back(res);
    endtask

    function automatic t_cmd make_palette(input logic [7:0] slot, input logic [15:0] color);
        t_cmd c;
        c.action            = ipc_pkg::ACT_PALETTE;
        c.palette_slot      = slot;
        c.palette_color     = color;
        c.pixel_x           = 10'($urandom);
        c.pixel_y           = 10'($urandom);
        c.color_index       = 8'($urandom);
        c.use_transparency  = 1'($urandom);
        c.transparent_index = 8'($urandom);
        return c;
    endfunction

    function automatic t_cmd make_pixel(input logic [9:0] x, input logic [9:0] y,
                                        input logic [7:0] ci, input logic use_t,
                                        input logic [7:0] ti);
        t_cmd c;
        c.action            = ipc_pkg::ACT_PIXEL;
        c.palette_slot      = 8'($urandom);
        c.palette_color     = 16'($urandom);
        c.pixel_x           = x;
        c.pixel_y           = y;
        c.color_index       = ci;
        c.use_transparency  = use_t;
        c.transparent_index = ti;
        return c;
    endfunction

    // Mostly back-to-back or short gaps, a few long ones, and bursts with none.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (src_burst > 0) begin
            src_burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            src_burst = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 2);
        if (roll < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Offer one command, wait for the transfer, then idle for gap cycles.
    // Valid stays high when gap is zero so the next command follows directly.
    task automatic send_cmd(input t_cmd cmd, input int unsigned gap);
        in_if.valid             <= 1'b1;
        in_if.action            <= cmd.action;
        in_if.palette_slot      <= cmd.palette_slot;
        in_if.palette_color     <= cmd.palette_color;
        in_if.pixel_x           <= cmd.pixel_x;
        in_if.pixel_y           <= cmd.pixel_y;
        in_if.color_index       <= cmd.color_index;
        in_if.use_transparency  <= cmd.use_transparency;
        in_if.transparent_index <= cmd.transparent_index;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_composite(cmd);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Extremes, every special case, palette read right after write.
    task automatic test_directed();
        send_cmd(make_pixel(10'd0, 10'd0, 8'd5, 1'b0, 8'd5), 0);          // black palette
        send_cmd(make_palette(8'd0, 16'hFFFF), 0);
        send_cmd(make_palette(8'd255, 16'hF800), 0);
        send_cmd(make_palette(8'd1, 16'h07E0), 0);
        send_cmd(make_palette(8'd2, 16'h001F), 0);
        send_cmd(make_palette(8'hAA, 16'h5555), 0);
        send_cmd(make_palette(8'h55, 16'hAAAA), 0);
        send_cmd(make_pixel(10'd0, 10'd0, 8'd255, 1'b0, 8'd0), 0);
        send_cmd(make_pixel(10'd319, 10'd239, 8'd1, 1'b1, 8'd0), 0);
        // transparent hit on the location just written: keeps index 1
        send_cmd(make_pixel(10'd319, 10'd239, 8'd7, 1'b1, 8'd7), 0);
        send_cmd(make_pixel(10'd319, 10'd0, 8'd2, 1'b1, 8'd3), 0);
        // equal indices with transparency off still write
        send_cmd(make_pixel(10'd0, 10'd239, 8'd0, 1'b0, 8'd0), 0);
        send_cmd(make_pixel(10'd320, 10'd0, 8'hAA, 1'b0, 8'd0), 0);       // off screen
        send_cmd(make_pixel(10'd0, 10'd240, 8'hAA, 1'b0, 8'd0), 0);
        send_cmd(make_pixel(10'd1023, 10'd1023, 8'hAA, 1'b0, 8'd0), 0);
        send_cmd(make_pixel(10'd320, 10'd239, 8'h55, 1'b0, 8'd0), 0);
        send_cmd(make_pixel(10'd319, 10'd240, 8'h55, 1'b0, 8'd0), 0);
        // palette rewrite followed at once by a pixel that reads it back
        send_cmd(make_palette(8'd255, 16'h1234), 0);
        send_cmd(make_pixel(10'd0, 10'd0, 8'd9, 1'b1, 8'd9), 0);
        send_cmd(make_pixel(10'd160, 10'd120, 8'hAA, 1'b1, 8'h55), 0);
        send_cmd(make_pixel(10'd160, 10'd120, 8'h55, 1'b0, 8'h55), 3);
        send_cmd(make_pixel(10'd160, 10'd120, 8'hFF, 1'b1, 8'hFF), 1);
        send_cmd(make_palette(8'd0, 16'h0000), 0);
        send_cmd(make_pixel(10'd0, 10'd239, 8'd4, 1'b1, 8'd4), 0);
    endtask

    // Mixed palette writes and pixels over the whole field ranges, biased to a
    // small area so that transparency shows older frame contents.
    task automatic test_random_mix(input int unsigned count);
        int unsigned roll;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  ci;
        logic [7:0]  ti;
        repeat (count) begin
            if ($urandom_range(0, 99) < 20) begin
                send_cmd(make_palette(8'($urandom), 16'($urandom)), pick_gap());
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    x = 10'($urandom_range(0, 7));
                    y = 10'($urandom_range(0, 3));
                end else if (roll < 80) begin
                    x = 10'($urandom_range(0, DISP_W-1));
                    y = 10'($urandom_range(0, DISP_H-1));
                end else if (roll < 90) begin
                    x = $urandom_range(0, 1) ? 10'(DISP_W-1) : 10'd0;
                    y = $urandom_range(0, 1) ? 10'(DISP_H-1) : 10'd0;
                end else begin
                    x = 10'($urandom);
                    y = 10'($urandom);
                end
                ci = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
                ti = ($urandom_range(0, 99) < 40) ? ci : 8'($urandom);
                send_cmd(make_pixel(x, y, ci, 1'($urandom), ti), pick_gap());
            end
        end
    endtask

    // Few locations, few slots, mostly back to back: read-after-write hazards
    // in both the frame buffer and the palette.
    task automatic test_hot_spot(input int unsigned count);
        logic [7:0] ci;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                send_cmd(make_palette(8'($urandom_range(0, 3)), 16'($urandom)),
                         ($urandom_range(0, 3) == 0) ? pick_gap() : 0);
            end else begin
                ci = 8'($urandom_range(0, 3));
                send_cmd(make_pixel(10'($urandom_range(0, 1)), 10'($urandom_range(0, 1)),
                                    ci, 1'($urandom), 8'($urandom_range(0, 3))),
                         ($urandom_range(0, 3) == 0) ? pick_gap() : 0);
            end
        end
    endtask

    // Receiver holds off for a long stretch while pixels keep coming, so the
    // output queue fills and the input stalls.
    task automatic test_output_stall(input int unsigned count);
        hold_req <= ~hold_req;
        repeat (count) begin
            send_cmd(make_pixel(10'($urandom_range(0, DISP_W-1)),
                                10'($urandom_range(0, DISP_H-1)),
                                8'($urandom), 1'($urandom), 8'($urandom)), 0);
        end
    endtask

    // Receiver: random stalls, runs of steady ready, and the requested hold-off.
    initial begin : sink_side
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned roll;
        bit          hold_seen;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        hold_seen  = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                out_if.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    run_left = $urandom_range(0, 60);
                    out_if.ready <= 1'b1;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 75)      stall_left = $urandom_range(0, 2);
                    else if (roll < 95) stall_left = $urandom_range(3, 11);
                    else                stall_left = $urandom_range(19, 59);
                    out_if.ready <= 1'b0;
                end
            end
        end
    end

    // Compare each output transfer with the oldest predicted pixel.
    initial begin : result_check
        ipc_pkg::t_out_item got;
        ipc_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.out_x = out_if.out_x;
                got.out_y = out_if.out_y;
                got.red   = out_if.red;
                got.green = out_if.green;
                got.blue  = out_if.blue;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer x=%0d y=%0d rgb=%h%h%h",
                                    got.out_x, got.out_y, got.red, got.green, got.blue));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                        got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        report_mismatch($sformatf(
                            "got x=%0d y=%0d rgb=%h_%h_%h, want x=%0d y=%0d rgb=%h_%h_%h",
                            got.out_x, got.out_y, got.red, got.green, got.blue,
                            want.out_x, want.out_y, want.red, want.green, want.blue));
                    end
                end
            end
        end
    end

    initial begin
        mismatch_count = 0;
        src_burst      = 0;
        hold_req                <= 1'b0;
        i_rst_n                 <= 1'b0;
        in_if.valid             <= 1'b0;
        in_if.action            <= ipc_pkg::ACT_PALETTE;
        in_if.palette_slot      <= '0;
        in_if.palette_color     <= '0;
        in_if.pixel_x           <= '0;
        in_if.pixel_y           <= '0;
        in_if.color_index       <= '0;
        in_if.use_transparency  <= 1'b0;
        in_if.transparent_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the first transfer also waits out the frame clear after reset
        test_directed();
        test_random_mix(550);
        test_output_stall(40);
        test_hot_spot(250);
        test_output_stall(30);
        test_random_mix(260);

        in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
